// ----- rtl/ist_pkg.sv -----
`timescale 1ns / 1ps
package ist_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_SORT   = 2'd2,
        MODE_SEARCH = 2'd3
    } mode_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SORT_RDI,
        S_SORT_LDI,
        S_SORT_RDJ,
        S_SORT_CMP,
        S_SORT_WRI,
        S_SRCH_CHK,
        S_SRCH_RDR,
        S_SRCH_PREP,
        S_SRCH_MUL,
        S_SRCH_DIV,
        S_SRCH_MID,
        S_SRCH_CMP,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic clr_cnt;
        logic append;
        logic sort_init;
        logic rd_i;
        logic ld_i;
        logic rd_j;
        logic cmp_j;
        logic wr_i;
        logic srch_init;
        logic rd_l;
        logic rd_r;
        logic prep;
        logic mul;
        logic div_step;
        logic rd_mid;
        logic cmp_mid;
        logic res_ok;
        logic res_nf;
        logic res_full;
        logic res_found_l;
        logic res_found_mid;
        logic emit;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  cnt_zero;
        logic  cnt_full;
        logic  cnt_lt2;
        logic  j_last;
        logic  i_last;
        logic  l_gt_r;
        logic  keys_eq;
        logic  key_eq_kl;
        logic  out_of_range;
        logic  div_last;
        logic  key_eq_mid;
        logic  out_free;
    } stat_t;

endpackage

// ----- rtl/ist_ctrl.sv -----
`timescale 1ns / 1ps
module ist_ctrl
    import ist_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_EMIT;
                unique case (stat.mode)
                    MODE_CLEAR:
                    begin
                        cmd.clr_cnt = 1'b1;
                        cmd.res_ok  = 1'b1;
                    end
                    MODE_APPEND:
                    begin
                        if (stat.cnt_full)
                        begin
                            cmd.res_full = 1'b1;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                            cmd.res_ok = 1'b1;
                        end
                    end
                    MODE_SORT:
                    begin
                        if (stat.cnt_lt2)
                        begin
                            cmd.res_ok = 1'b1;
                        end
                        else
                        begin
                            cmd.sort_init = 1'b1;
                            state_next    = S_SORT_RDI;
                        end
                    end
                    MODE_SEARCH:
                    begin
                        if (stat.cnt_zero)
                        begin
                            cmd.res_nf = 1'b1;
                        end
                        else
                        begin
                            cmd.srch_init = 1'b1;
                            state_next    = S_SRCH_CHK;
                        end
                    end
                    default:
                    begin
                        cmd.res_ok = 1'b1;
                    end
                endcase
            end
            S_SORT_RDI:
            begin
                cmd.rd_i   = 1'b1;
                state_next = S_SORT_LDI;
            end
            S_SORT_LDI:
            begin
                cmd.ld_i   = 1'b1;
                state_next = S_SORT_RDJ;
            end
            S_SORT_RDJ:
            begin
                cmd.rd_j   = 1'b1;
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                cmd.cmp_j  = 1'b1;
                state_next = stat.j_last ? S_SORT_WRI : S_SORT_RDJ;
            end
            S_SORT_WRI:
            begin
                cmd.wr_i = 1'b1;
                if (stat.i_last)
                begin
                    cmd.res_ok = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_SORT_RDI;
                end
            end
            S_SRCH_CHK:
            begin
                if (stat.l_gt_r)
                begin
                    cmd.res_nf = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.rd_l   = 1'b1;
                    state_next = S_SRCH_RDR;
                end
            end
            S_SRCH_RDR:
            begin
                cmd.rd_r   = 1'b1;
                state_next = S_SRCH_PREP;
            end
            S_SRCH_PREP:
            begin
                if (stat.keys_eq)
                begin
                    cmd.res_found_l = stat.key_eq_kl;
                    cmd.res_nf      = !stat.key_eq_kl;
                    state_next      = S_EMIT;
                end
                else
                begin
                    cmd.prep   = 1'b1;
                    state_next = S_SRCH_MUL;
                end
            end
            S_SRCH_MUL:
            begin
                if (stat.out_of_range)
                begin
                    cmd.res_nf = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_SRCH_DIV;
                end
            end
            S_SRCH_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_SRCH_MID;
                end
            end
            S_SRCH_MID:
            begin
                cmd.rd_mid = 1'b1;
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (stat.key_eq_mid)
                begin
                    cmd.res_found_mid = 1'b1;
                    state_next        = S_EMIT;
                end
                else
                begin
                    cmd.cmp_mid = 1'b1;
                    state_next  = S_SRCH_CHK;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg == S_DISPATCH))
        else $error("transfer taken but dispatch skipped");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (state_reg == S_IDLE))
        else $error("result emitted outside of completion");

endmodule

// ----- rtl/ist_dp.sv -----
`timescale 1ns / 1ps
module ist_dp
    import ist_pkg::*;
#(
    parameter int TABLE_DEPTH = 128
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic        [1:0]  mode,
    input  logic signed [31:0] key,
    input  logic signed [31:0] data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic        [1:0]  status,
    output logic        [6:0]  position,
    output logic signed [31:0] found_data,
    input  cmd_t               cmd,
    output stat_t              stat
);

    localparam int AW  = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int LW  = AW + 2;
    localparam int DVW = 34 + AW;
    localparam int BW  = $clog2(AW + 1);
    localparam int PW  = (AW > 7) ? AW : 7;

    logic signed [31:0] key_mem [TABLE_DEPTH];
    logic signed [31:0] data_mem [TABLE_DEPTH];

    mode_t              mode_reg;
    logic signed [31:0] key_reg;
    logic signed [31:0] data_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic signed [31:0] ki_reg;
    logic signed [31:0] di_reg;
    logic signed [31:0] rk_reg;
    logic signed [31:0] rd_reg;
    logic signed [31:0] kl_reg;
    logic signed [31:0] dl_reg;
    logic signed [LW-1:0] l_reg;
    logic signed [LW-1:0] r_reg;
    logic signed [33:0] num_reg;
    logic signed [33:0] den_reg;
    logic [DVW-1:0]     rem_reg;
    logic [DVW-1:0]     dsh_reg;
    logic [AW-1:0]      q_reg;
    logic [BW-1:0]      bcnt_reg;
    logic [AW-1:0]      mid_reg;
    logic [1:0]         res_status_reg;
    logic [AW-1:0]      res_pos_reg;
    logic signed [31:0] res_data_reg;
    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [6:0]         position_reg;
    logic signed [31:0] found_data_reg;

    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [31:0]   wr_key;
    logic signed [31:0]   wr_data;
    logic signed [LW-1:0] mid_sum;
    logic signed [LW-1:0] span;
    logic signed [33:0]   num_raw;
    logic signed [33:0]   den_raw;
    logic                 div_ge;
    logic [PW-1:0]        pos_ext;
    logic [CW:0]          i_plus2;
    logic [31+AW:0]       prod;

    assign mid_sum = l_reg + LW'(q_reg);
    assign span    = r_reg - l_reg;
    assign num_raw = 34'(key_reg) - 34'(kl_reg);
    assign den_raw = 34'(rk_reg) - 34'(kl_reg);
    assign div_ge  = (rem_reg >= dsh_reg);
    assign pos_ext = PW'(res_pos_reg);
    assign i_plus2 = (CW + 1)'(i_reg) + (CW + 1)'(2);
    assign prod    = num_reg[31:0] * span[AW-1:0];

    always_comb
    begin
        priority if (cmd.rd_i)
        begin
            rd_addr = i_reg[AW-1:0];
        end
        else if (cmd.rd_j)
        begin
            rd_addr = j_reg[AW-1:0];
        end
        else if (cmd.rd_l)
        begin
            rd_addr = l_reg[AW-1:0];
        end
        else if (cmd.rd_r)
        begin
            rd_addr = r_reg[AW-1:0];
        end
        else
        begin
            rd_addr = mid_sum[AW-1:0];
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg[AW-1:0];
        wr_key  = key_reg;
        wr_data = data_reg;
        priority if (cmd.append)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.cmp_j && (rk_reg < ki_reg))
        begin
            wr_en   = 1'b1;
            wr_addr = j_reg[AW-1:0];
            wr_key  = ki_reg;
            wr_data = di_reg;
        end
        else if (cmd.wr_i)
        begin
            wr_en   = 1'b1;
            wr_addr = i_reg[AW-1:0];
            wr_key  = ki_reg;
            wr_data = di_reg;
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]  <= wr_key;
            data_mem[wr_addr] <= wr_data;
        end
        rk_reg <= key_mem[rd_addr];
        rd_reg <= data_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg <= mode_t'(mode);
            key_reg  <= key;
            data_reg <= data;
        end
        if (cmd.sort_init)
        begin
            i_reg <= '0;
        end
        if (cmd.ld_i)
        begin
            ki_reg <= rk_reg;
            di_reg <= rd_reg;
            j_reg  <= i_reg + CW'(1);
        end
        if (cmd.cmp_j)
        begin
            j_reg <= j_reg + CW'(1);
            if (rk_reg < ki_reg)
            begin
                ki_reg <= rk_reg;
                di_reg <= rd_reg;
            end
        end
        if (cmd.wr_i)
        begin
            i_reg <= i_reg + CW'(1);
        end
        if (cmd.srch_init)
        begin
            l_reg <= '0;
            r_reg <= LW'(cnt_reg) - LW'(1);
        end
        if (cmd.rd_r)
        begin
            kl_reg <= rk_reg;
            dl_reg <= rd_reg;
        end
        if (cmd.prep)
        begin
            num_reg <= den_raw[33] ? -num_raw : num_raw;
            den_reg <= den_raw[33] ? -den_raw : den_raw;
        end
        if (cmd.mul)
        begin
            rem_reg  <= DVW'({prod, 1'b0}) + DVW'(den_reg[31:0]);
            dsh_reg  <= DVW'({den_reg[31:0], 1'b0}) << (AW - 1);
            q_reg    <= '0;
            bcnt_reg <= BW'(AW - 1);
        end
        if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg  <= dsh_reg >> 1;
            q_reg    <= AW'({q_reg, div_ge});
            bcnt_reg <= bcnt_reg - BW'(1);
        end
        if (cmd.rd_mid)
        begin
            mid_reg <= mid_sum[AW-1:0];
        end
        if (cmd.cmp_mid)
        begin
            if (key_reg < rk_reg)
            begin
                r_reg <= LW'(mid_reg) - LW'(1);
            end
            else
            begin
                l_reg <= LW'(mid_reg) + LW'(1);
            end
        end
        if (cmd.res_ok || cmd.res_nf || cmd.res_full)
        begin
            res_status_reg <= cmd.res_full ? ST_FULL : (cmd.res_nf ? ST_NOT_FOUND : ST_OK);
            res_pos_reg    <= '0;
            res_data_reg   <= '0;
        end
        if (cmd.res_found_l)
        begin
            res_status_reg <= ST_OK;
            res_pos_reg    <= l_reg[AW-1:0];
            res_data_reg   <= dl_reg;
        end
        if (cmd.res_found_mid)
        begin
            res_status_reg <= ST_OK;
            res_pos_reg    <= mid_reg;
            res_data_reg   <= rd_reg;
        end
        if (cmd.emit)
        begin
            status_reg     <= res_status_reg;
            position_reg   <= pos_ext[6:0];
            found_data_reg <= res_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_cnt)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.append)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign position   = position_reg;
    assign found_data = found_data_reg;

    always_comb
    begin
        stat.mode         = mode_reg;
        stat.cnt_zero     = (cnt_reg == '0);
        stat.cnt_full     = (cnt_reg == CW'(TABLE_DEPTH));
        stat.cnt_lt2      = (cnt_reg < CW'(2));
        stat.j_last       = ((j_reg + CW'(1)) == cnt_reg);
        stat.i_last       = (i_plus2 >= (CW + 1)'(cnt_reg));
        stat.l_gt_r       = (l_reg > r_reg);
        stat.keys_eq      = (kl_reg == rk_reg);
        stat.key_eq_kl    = (key_reg == kl_reg);
        stat.out_of_range = (num_reg < 0) || (num_reg > den_reg);
        stat.div_last     = (bcnt_reg == '0);
        stat.key_eq_mid   = (key_reg == rk_reg);
        stat.out_free     = !out_valid_reg || !out_stall;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_mid |-> (mid_sum >= l_reg) && (mid_sum <= r_reg))
        else $error("probe outside search range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (position == '0) && (found_data == '0))
        else $error("miss result carries a position or data");

endmodule

// ----- rtl/interpolation_search_table.sv -----
`timescale 1ns / 1ps
// channel   valid      stall      payload
// input     in_valid   in_stall   mode, key, data
// output    out_valid  out_stall  status, position, found_data
//
// Clear and append finish in dispatch; search reads both range ends per probe,
// then divides with AW = clog2(TABLE_DEPTH) quotient bits and reads the probe.
// Sort makes n*(n-1)/2 key compares for n entries, plus a read and a write
// per outer pass, bound by the single table read port.
// Reset empties the table; stored entries are not cleared.
// One item is in flight at a time; the next transfer is taken once the
// result sits in the output register, which holds while out_stall is high.
module interpolation_search_table
    import ist_pkg::*;
#(
    parameter int TABLE_DEPTH = 128
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic        [1:0]  mode,
    input  logic signed [31:0] key,
    input  logic signed [31:0] data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic        [1:0]  status,
    output logic        [6:0]  position,
    output logic signed [31:0] found_data
);

    cmd_t  cmd;
    stat_t stat;

    ist_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ist_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode),
        .key        (key),
        .data       (data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .position   (position),
        .found_data (found_data),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule

// ----- tb/ist_result_checker.sv -----
`timescale 1ns / 1ps
module ist_result_checker
    import ist_pkg::*;
#(
    parameter int TABLE_DEPTH = 128
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic        [1:0]  mode,
    input  logic signed [31:0] key,
    input  logic signed [31:0] data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic        [1:0]  status,
    input  logic        [6:0]  position,
    input  logic signed [31:0] found_data,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [1:0]  st;
        logic [6:0]  pos;
        logic [31:0] fdata;
    } table_result_t;

    longint        tbl_key  [TABLE_DEPTH];
    longint        tbl_data [TABLE_DEPTH];
    int            n_entries;
    table_result_t expected_results [$];

    function automatic bit find_key(input longint k, output int hit);
        longint l, r, kl, kr, num, den, mid, km;
        hit = 0;
        if (n_entries == 0)
            return 0;
        l = 0;
        r = n_entries - 1;
        while (l <= r) begin
            kl = tbl_key[l];
            kr = tbl_key[r];
            if (kl == kr) begin
                hit = int'(l);
                return kl == k;
            end
            num = k - kl;
            den = kr - kl;
            if (den < 0) begin
                num = -num;
                den = -den;
            end
            if (num < 0 || num > den)
                return 0;
            mid = l + (2 * num * (r - l) + den) / (2 * den);
            km = tbl_key[mid];
            if (k < km)
                r = mid - 1;
            else if (k > km)
                l = mid + 1;
            else begin
                hit = int'(mid);
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic table_result_t table_apply(input mode_t m, input longint k,
                                                  input longint d);
        table_result_t res;
        longint        t;
        int            hit;
        res = '0;
        res.st = ST_OK;
        case (m)
            MODE_CLEAR: n_entries = 0;
            MODE_APPEND:
                if (n_entries >= TABLE_DEPTH)
                    res.st = ST_FULL;
                else begin
                    tbl_key[n_entries] = k;
                    tbl_data[n_entries] = d;
                    n_entries++;
                end
            MODE_SORT:
                for (int i = 0; i + 1 < n_entries; i++)
                    for (int j = i + 1; j < n_entries; j++)
                        if (tbl_key[i] > tbl_key[j]) begin
                            t = tbl_key[i];
                            tbl_key[i] = tbl_key[j];
                            tbl_key[j] = t;
                            t = tbl_data[i];
                            tbl_data[i] = tbl_data[j];
                            tbl_data[j] = t;
                        end
            default:
                if (find_key(k, hit)) begin
                    res.pos = hit[6:0];
                    res.fdata = tbl_data[hit][31:0];
                end
                else
                    res.st = ST_NOT_FOUND;
        endcase
        return res;
    endfunction

    assign pending = expected_results.size();

    initial
    begin
        fail_count = 0;
        n_entries = 0;
    end

    always @(posedge clk)
    begin
        table_result_t exp_res;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result status=%0d position=%0d data=%0h",
                             $time, status, position, found_data);
                    fail_count++;
                end
                else begin
                    exp_res = expected_results.pop_front();
                    if (status !== exp_res.st) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_res.st, status);
                        fail_count++;
                    end
                    if (position !== exp_res.pos) begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, exp_res.pos, position);
                        fail_count++;
                    end
                    if (found_data !== exp_res.fdata) begin
                        $display("%0t: found_data expected %h actual %h",
                                 $time, exp_res.fdata, found_data);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(table_apply(mode_t'(mode), longint'(key),
                                                       longint'(data)));
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import ist_pkg::*;

    localparam int DEPTH = 128;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic        [1:0]  mode = MODE_CLEAR;
    logic signed [31:0] key = '0;
    logic signed [31:0] data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic        [1:0]  status;
    logic        [6:0]  position;
    logic signed [31:0] found_data;

    int fail_count;
    int pending;
    int sent = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    bit pressure_done = 0;
    logic signed [31:0] known_keys [$];

    interpolation_search_table #(.TABLE_DEPTH(DEPTH)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .key(key), .data(data),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .position(position), .found_data(found_data)
    );

    ist_result_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .key(key), .data(data),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .position(position), .found_data(found_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stall, plus one long hold-off to back up the input
    always @(posedge clk)
    begin
        if (!pressure_done && sent >= 300) begin
            pressure_done <= 1;
            out_stall <= 1'b1;
            repeat (400) @(posedge clk);
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_op(input mode_t m, input logic signed [31:0] k,
                           input logic signed [31:0] d);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        key <= k;
        data <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
        if (m == MODE_APPEND)
            known_keys.push_back(k);
        else if (m == MODE_CLEAR)
            known_keys.delete();
    endtask

    function automatic logic signed [31:0] pick_key(input int style);
        case (style)
            0: return $urandom_range(20) - 10;
            1: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                        : 32'sh80000000 + $urandom_range(3);
            2: return $urandom_range(4000) - 2000;
            default: return $urandom;
        endcase
    endfunction

    task automatic table_sequence();
        int n, style, searches;
        if ($urandom_range(9) < 8)
            send_op(MODE_CLEAR, $urandom, $urandom);
        n = ($urandom_range(24) == 0) ? DEPTH + 2 : $urandom_range(1, 12);
        style = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0)
                send_op(mode_t'($urandom_range(3)), $urandom, $urandom);
            send_op(MODE_APPEND, pick_key(style), $urandom);
        end
        if ($urandom_range(99) < 85)
            send_op(MODE_SORT, $urandom, $urandom);
        searches = $urandom_range(2, 8);
        for (int i = 0; i < searches; i++)
            if (known_keys.size() > 0 && $urandom_range(99) < 60)
                send_op(MODE_SEARCH, known_keys[$urandom_range(known_keys.size() - 1)],
                        $urandom);
            else
                send_op(MODE_SEARCH, pick_key(style), $urandom);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(MODE_SEARCH, 32'sd5, 32'sd0);
        send_op(MODE_SORT, 32'sd0, 32'sd0);
        send_op(MODE_APPEND, 32'sd7, 32'sh7fffffff);
        send_op(MODE_SORT, 32'sd0, 32'sd0);
        send_op(MODE_SEARCH, 32'sd7, 32'sd0);
        send_op(MODE_SEARCH, 32'sd8, 32'sd0);
        send_op(MODE_APPEND, 32'sh7fffffff, 32'sh80000000);
        send_op(MODE_APPEND, 32'sh80000000, 32'shffffffff);
        send_op(MODE_APPEND, 32'sd0, 32'sd0);
        send_op(MODE_SEARCH, 32'sd0, 32'sd0);
        send_op(MODE_SORT, 32'sd0, 32'sd0);
        send_op(MODE_SEARCH, 32'sh80000000, 32'sd0);
        send_op(MODE_SEARCH, 32'sh7fffffff, 32'sd0);
        send_op(MODE_SEARCH, 32'sd0, 32'sd0);
        send_op(MODE_SEARCH, 32'sd1, 32'sd0);
        send_op(MODE_APPEND, 32'sd7, 32'sd3);
        send_op(MODE_SORT, 32'sd0, 32'sd0);
        send_op(MODE_SEARCH, 32'sd7, 32'sd0);
        send_op(MODE_CLEAR, 32'shffffffff, 32'shffffffff);
        send_op(MODE_SEARCH, 32'sd7, 32'sd0);

        while (sent < 1300) begin
            case ((sent * 5) / 1300)
                1: begin idle_pct = 54; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 54; end
                3: begin idle_pct = 33; stall_pct = 33; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            table_sequence();
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
